[rtl/crm_pkg.sv]
// crm_pkg: widths, reset values, register indexes and state codes for the
// capture speed meter. No dependencies; every other rtl file depends on it.
package crm_pkg;

    // field widths
    localparam int CAPTURE_BITS = 16;
    localparam int SPEED_BITS   = 24;
    localparam int NUM_BITS     = 24;
    localparam int THR_BITS     = 8;
    localparam int ADDR_BITS    = 1;
    localparam int DATA_BITS    = 24;
    localparam int COUNT_BITS   = $clog2(NUM_BITS + 1);

    // configuration register indexes
    localparam logic [ADDR_BITS-1:0] REG_RATE_NUMERATOR   = 1'd0;
    localparam logic [ADDR_BITS-1:0] REG_CHANGE_THRESHOLD = 1'd1;

    // configuration reset values
    localparam logic [NUM_BITS-1:0] NUM_RESET = 24'd1200000;
    localparam logic [THR_BITS-1:0] THR_RESET = 8'd5;

    // item kinds
    localparam logic FUNC_OVERFLOW = 1'b0;
    localparam logic FUNC_CAPTURE  = 1'b1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

endpackage

[rtl/crm_item_if.sv]
// crm_item_if: input request channel (timer overflow or capture event)
// depends on crm_pkg for field widths
interface crm_item_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [crm_pkg::CAPTURE_BITS-1:0]    capture_time;

    modport source (output valid, output func, output capture_time, input ready);
    modport sink   (input valid, input func, input capture_time, output ready);
endinterface

[rtl/crm_result_if.sv]
// crm_result_if: result request channel, one per accepted item
// depends on crm_pkg for field widths
interface crm_result_if;
    logic                              valid;
    logic                              ready;
    logic [crm_pkg::SPEED_BITS-1:0]    shown_speed;
    logic                              shown_updated;
    logic [crm_pkg::SPEED_BITS-1:0]    measured_speed;
    logic                              measure_valid;
    logic                              zero_period;

    modport source (output valid, output shown_speed, output shown_updated,
                    output measured_speed, output measure_valid,
                    output zero_period, input ready);
    modport sink   (input valid, input shown_speed, input shown_updated,
                    input measured_speed, input measure_valid,
                    input zero_period, output ready);
endinterface

[rtl/crm_cfg_if.sv]
// crm_cfg_if: configuration write channel, register index plus data
// depends on crm_pkg for index and data widths
interface crm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [crm_pkg::ADDR_BITS-1:0]    addr;
    logic [crm_pkg::DATA_BITS-1:0]    data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/crm_divider.sv]
// crm_divider: restoring bit-serial divider, one quotient bit per cycle
// depends on crm_pkg for dividend, divisor and counter widths
module crm_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [crm_pkg::NUM_BITS-1:0]        dividend,
    input  logic [crm_pkg::CAPTURE_BITS-1:0]    divisor,
    output logic                                done,
    output logic [crm_pkg::NUM_BITS-1:0]        quotient
);
    import crm_pkg::*;

    logic [CAPTURE_BITS-1:0] rem_reg;
    logic [CAPTURE_BITS-1:0] rem_next;
    logic [CAPTURE_BITS-1:0] div_reg;
    logic [NUM_BITS-1:0]     quo_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [CAPTURE_BITS:0]   trial;
    logic                    fits;

    // shared subtract and compare step
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_BITS-1]};
        fits  = (trial >= {1'b0, div_reg});
        if (fits)
        begin
            rem_next = CAPTURE_BITS'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[CAPTURE_BITS-1:0];
        end
    end

    // control: bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= COUNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == COUNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/capture_rpm_meter.sv]
// capture_rpm_meter: top level of the capture speed meter
// depends on crm_pkg, crm_item_if, crm_result_if, crm_cfg_if, crm_divider
//
//  channel  | dir | payload                                        | accepted when
//  ---------+-----+------------------------------------------------+--------------
//  item     | in  | func, capture_time                             | valid & ready
//  result   | out | shown_speed, shown_updated, measured_speed,    | valid & ready
//           |     | measure_valid, zero_period                     |
//  cfg      | in  | addr (0 rate_numerator, 1 change_threshold),   | valid & ready
//           |     | data                                           |
//
// an overflow, a re-arming capture or a zero period goes from accept through the
// done state to the output register; a measuring capture first spends the 24 steps of
// the bit-serial divider in the divide state. one item is in the sequencer at a time.
// reset clears the pending flag, reference timestamp and shown value and
// loads the register defaults. cfg is always ready. a stalled result holds
// in its output register while the next item is taken; that item waits in
// the done state until the register frees.
module capture_rpm_meter (
    input  logic              clk,
    input  logic              rst_n,
    crm_item_if.sink          item,
    crm_result_if.source      result,
    crm_cfg_if.sink           cfg
);
    import crm_pkg::*;

    logic [1:0]              state_reg;
    logic                    pending_reg;
    logic [CAPTURE_BITS-1:0] last_reg;
    logic [SPEED_BITS-1:0]   shown_reg;
    logic [NUM_BITS-1:0]     num_reg;
    logic [THR_BITS-1:0]     thr_reg;

    logic                    res_upd_reg;
    logic [SPEED_BITS-1:0]   res_meas_reg;
    logic                    res_mv_reg;
    logic                    res_zero_reg;

    logic                    out_valid_reg;
    logic [SPEED_BITS-1:0]   out_shown_reg;
    logic                    out_upd_reg;
    logic [SPEED_BITS-1:0]   out_meas_reg;
    logic                    out_mv_reg;
    logic                    out_zero_reg;

    logic                    accept;
    logic [CAPTURE_BITS-1:0] period;
    logic                    div_start;
    logic                    div_done;
    logic [NUM_BITS-1:0]     div_quotient;
    logic [SPEED_BITS-1:0]   diff;
    logic                    out_free;
    logic                    out_load;

    // handshakes
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    // capture period with timer wrap
    assign period    = item.capture_time - last_reg;
    assign div_start = accept && (item.func == FUNC_CAPTURE) && !pending_reg
                       && (period != '0);

    crm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (period),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // distance between new quotient and shown value
    always_comb
    begin
        if (div_quotient >= shown_reg)
        begin
            diff = div_quotient - shown_reg;
        end
        else
        begin
            diff = shown_reg - div_quotient;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= NUM_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_RATE_NUMERATOR:   num_reg <= cfg.data[NUM_BITS-1:0];
                REG_CHANGE_THRESHOLD: thr_reg <= cfg.data[THR_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // sequencer and meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            last_reg      <= '0;
            shown_reg     <= '0;
            res_upd_reg   <= 1'b0;
            res_meas_reg  <= '0;
            res_mv_reg    <= 1'b0;
            res_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_upd_reg  <= 1'b0;
                        res_meas_reg <= '0;
                        res_mv_reg   <= 1'b0;
                        if (item.func == FUNC_OVERFLOW)
                        begin
                            res_zero_reg <= 1'b0;
                            pending_reg  <= 1'b1;
                            state_reg    <= ST_DONE;
                        end
                        else if (pending_reg)
                        begin
                            res_zero_reg <= 1'b0;
                            last_reg     <= item.capture_time;
                            pending_reg  <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                        else
                        begin
                            last_reg     <= item.capture_time;
                            res_zero_reg <= (period == '0);
                            if (period == '0)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_meas_reg <= div_quotient;
                        res_mv_reg   <= 1'b1;
                        if (diff >= SPEED_BITS'(thr_reg))
                        begin
                            shown_reg   <= div_quotient;
                            res_upd_reg <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_shown_reg <= shown_reg;
            out_upd_reg   <= res_upd_reg;
            out_meas_reg  <= res_meas_reg;
            out_mv_reg    <= res_mv_reg;
            out_zero_reg  <= res_zero_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.shown_speed    = out_shown_reg;
    assign result.shown_updated  = out_upd_reg;
    assign result.measured_speed = out_meas_reg;
    assign result.measure_valid  = out_mv_reg;
    assign result.zero_period    = out_zero_reg;

    // an update only follows a real measurement
    a_upd_needs_meas: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_upd_reg |-> out_mv_reg)
        else $error("shown value updated without a measurement");

    // a zero period never comes with a quotient
    a_zero_no_meas: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |-> !out_mv_reg && (out_meas_reg == '0))
        else $error("zero period reported with a quotient");

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // the divider starts only from idle on an accepted capture
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started without entering the divide state");

endmodule

[tb/sv/crm_speed_checker.sv]
// crm_speed_checker: watches the item, result and cfg channels of the capture
// speed meter, predicts every result and compares it field by field.
// depends on crm_pkg, crm_item_if, crm_result_if and crm_cfg_if
module crm_speed_checker (
    input  logic    clk,
    input  logic    rst_n,
    crm_item_if     item,
    crm_result_if   result,
    crm_cfg_if      cfg,
    output int      fail_count,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import crm_pkg::*;

    typedef struct packed {
        logic [SPEED_BITS-1:0] shown_speed;
        logic                  shown_updated;
        logic [SPEED_BITS-1:0] measured_speed;
        logic                  measure_valid;
        logic                  zero_period;
    } speed_result_t;

    // predicted registers and state
    logic [NUM_BITS-1:0]     numerator;
    logic [THR_BITS-1:0]     threshold;
    logic                    overflow_seen;
    logic [CAPTURE_BITS-1:0] ref_stamp;
    logic [SPEED_BITS-1:0]   display_speed;

    speed_result_t expected_speeds[$];
    speed_result_t want;
    int            fail_tally;

    // advance the predicted state by one request and return its result
    function automatic speed_result_t measure_speed(input logic f,
                                                    input logic [CAPTURE_BITS-1:0] stamp);
        speed_result_t           r;
        logic [CAPTURE_BITS-1:0] period;
        logic [SPEED_BITS-1:0]   quotient;
        logic [SPEED_BITS-1:0]   gap;
        r = '0;
        if (f == FUNC_OVERFLOW)
        begin
            overflow_seen = 1'b1;
        end
        else if (overflow_seen)
        begin
            // first capture after an overflow only re-arms the reference
            ref_stamp     = stamp;
            overflow_seen = 1'b0;
        end
        else
        begin
            // period wraps modulo the timer width
            period    = stamp - ref_stamp;
            ref_stamp = stamp;
            if (period == '0)
            begin
                r.zero_period = 1'b1;
            end
            else
            begin
                quotient         = numerator / period;
                r.measured_speed = quotient;
                r.measure_valid  = 1'b1;
                gap = (quotient >= display_speed) ? quotient - display_speed
                                                  : display_speed - quotient;
                if (gap >= threshold)
                begin
                    display_speed   = quotient;
                    r.shown_updated = 1'b1;
                end
            end
        end
        r.shown_speed = display_speed;
        return r;
    endfunction

    // track config, compare results, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numerator     = NUM_RESET;
            threshold     = THR_RESET;
            overflow_seen = 1'b0;
            ref_stamp     = '0;
            display_speed = '0;
            fail_tally    = 0;
            expected_speeds.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_RATE_NUMERATOR:   numerator = cfg.data[NUM_BITS-1:0];
                    REG_CHANGE_THRESHOLD: threshold = cfg.data[THR_BITS-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    $error("result request with no prediction waiting");
                    fail_tally++;
                end
                else
                begin
                    want = expected_speeds.pop_front();
                    if (result.shown_speed !== want.shown_speed)
                    begin
                        $error("shown_speed expected %0d actual %0d",
                               want.shown_speed, result.shown_speed);
                        fail_tally++;
                    end
                    if (result.shown_updated !== want.shown_updated)
                    begin
                        $error("shown_updated expected %0d actual %0d",
                               want.shown_updated, result.shown_updated);
                        fail_tally++;
                    end
                    if (result.measured_speed !== want.measured_speed)
                    begin
                        $error("measured_speed expected %0d actual %0d",
                               want.measured_speed, result.measured_speed);
                        fail_tally++;
                    end
                    if (result.measure_valid !== want.measure_valid)
                    begin
                        $error("measure_valid expected %0d actual %0d",
                               want.measure_valid, result.measure_valid);
                        fail_tally++;
                    end
                    if (result.zero_period !== want.zero_period)
                    begin
                        $error("zero_period expected %0d actual %0d",
                               want.zero_period, result.zero_period);
                        fail_tally++;
                    end
                end
            end

            if (item.valid && item.ready)
                expected_speeds.push_back(measure_speed(item.func, item.capture_time));

            fail_count  <= fail_tally;
            outstanding <= expected_speeds.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// testbench: drives overflow and capture requests and register writes into
// capture_rpm_meter and gives the verdict from crm_speed_checker.
// depends on crm_pkg, the three channel interfaces and crm_speed_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 165;
    localparam int PHASES      = 7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    bit   gaps_on = 1'b1;
    int   hold_asked = 0;

    logic [CAPTURE_BITS-1:0] stamp_now = '0;
    logic [NUM_BITS-1:0]     phase_num [PHASES];
    logic [THR_BITS-1:0]     phase_thr [PHASES];

    crm_item_if   item_ch ();
    crm_result_if result_ch ();
    crm_cfg_if    cfg_ch ();

    capture_rpm_meter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    crm_speed_checker speed_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin : result_receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
        end
    end

    // watchdog on cycles with no request accepted anywhere
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // offer one request; valid stays high unless a gap is taken
    task automatic offer_request(input logic f, input logic [CAPTURE_BITS-1:0] t);
        if (gaps_on && $urandom_range(99) < 10)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= f;
        item_ch.capture_time <= t;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic offer_capture(input logic [CAPTURE_BITS-1:0] t);
        stamp_now = t;
        offer_request(FUNC_CAPTURE, t);
    endtask

    // both registers, threshold write carries random upper data bits
    task automatic write_settings(input logic [NUM_BITS-1:0] num,
                                  input logic [THR_BITS-1:0] thr);
        logic [DATA_BITS-1:0] word;
        word = DATA_BITS'($urandom);
        word[THR_BITS-1:0] = thr;
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= REG_RATE_NUMERATOR;
        cfg_ch.data  <= DATA_BITS'(num);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.addr <= REG_CHANGE_THRESHOLD;
        cfg_ch.data <= word;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly plausible capture trains, some overflows, jumps and repeats
    task automatic offer_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            offer_request(FUNC_OVERFLOW, CAPTURE_BITS'($urandom));
        else
        begin
            if (pick < 12)
                stamp_now = CAPTURE_BITS'($urandom);
            else if (pick >= 60)
                stamp_now = stamp_now + CAPTURE_BITS'($urandom_range(31, 2000));
            else if (pick >= 40)
                stamp_now = stamp_now + CAPTURE_BITS'($urandom_range(1, 30));
            else if (pick >= 16)
                stamp_now = stamp_now + CAPTURE_BITS'($urandom_range(2001, 65535));
            offer_request(FUNC_CAPTURE, stamp_now);
        end
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.func         <= FUNC_OVERFLOW;
        item_ch.capture_time <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.addr          <= REG_RATE_NUMERATOR;
        cfg_ch.data          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset defaults
        offer_capture(16'h0000);                // zero period against reset reference
        offer_capture(16'd100);
        offer_capture(16'd102);
        offer_capture(16'd103);                 // period of one, largest quotient
        offer_capture(16'hFFFF);
        offer_capture(16'hFFFF);                // zero period
        offer_capture(16'h0000);                // timer wrap
        offer_capture(16'h0002);
        offer_capture(16'h0004);                // same quotient, no display change
        offer_request(FUNC_OVERFLOW, 16'hFFFF);
        offer_capture(16'h5555);                // re-arm after overflow
        offer_capture(16'hAAAA);
        offer_request(FUNC_OVERFLOW, 16'hAAAA);
        offer_request(FUNC_OVERFLOW, 16'h5555);
        offer_capture(16'hAAAA);                // re-arm, same stamp as reference
        offer_capture(16'hAAAA + 16'd4660);     // quotient 257
        offer_capture(stamp_now + 16'd4743);    // quotient 253, just under threshold
        offer_capture(stamp_now + 16'd4761);    // quotient 252, exactly at threshold
        offer_capture(stamp_now + 16'd65535);   // longest period
        offer_request(FUNC_OVERFLOW, 16'h0000);
        offer_capture(stamp_now);               // re-arm with unchanged stamp
        item_ch.valid <= 1'b0;
        wait_drained();

        // register settings per phase, extremes included
        phase_num[0] = NUM_RESET;          phase_thr[0] = THR_RESET;
        phase_num[1] = '1;                 phase_thr[1] = '0;
        phase_num[2] = NUM_BITS'(1);       phase_thr[2] = '1;
        phase_num[3] = '0;                 phase_thr[3] = THR_RESET;
        phase_num[4] = NUM_BITS'($urandom); phase_thr[4] = THR_BITS'($urandom);
        phase_num[5] = NUM_BITS'(4800);    phase_thr[5] = THR_BITS'(2);
        phase_num[6] = NUM_BITS'($urandom); phase_thr[6] = THR_BITS'($urandom);

        for (int p = 0; p < PHASES; p++)
        begin
            write_settings(phase_num[p], phase_thr[p]);
            // long result hold-off while requests keep coming
            if (p == 1)
                hold_asked++;
            // one stretch with no gaps on either side
            gaps_on = (p != 4);
            repeat (PHASE_ITEMS) offer_random_item();
            item_ch.valid <= 1'b0;
            wait_drained();
        end
        gaps_on = 1'b1;

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/crm_pkg.sv
rtl/crm_item_if.sv
rtl/crm_result_if.sv
rtl/crm_cfg_if.sv
rtl/crm_divider.sv
rtl/capture_rpm_meter.sv
tb/sv/crm_speed_checker.sv
tb/sv/testbench.sv
